// File: rtl/core/cpsu_pkg.sv
`timescale 1ns / 1ps

package cpsu_pkg;

    // Command codes
    localparam logic [1:0] MODE_ENTER = 2'd0;
    localparam logic [1:0] MODE_LEAVE = 2'd1;
    localparam logic [1:0] MODE_FRAME = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_STACK_EMPT = 2'd1;
    localparam logic [1:0] ST_STACK_FULL = 2'd2;
    localparam logic [1:0] ST_TABLE_FULL = 2'd3;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [47:0] timestamp;
        logic [15:0] func_id;
        logic [4:0]  entry_index;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        entry_valid;
        logic [15:0] entry_func_id;
        logic [31:0] call_count;
        logic [63:0] total_cycles;
        logic [47:0] min_cycles;
        logic [47:0] max_cycles;
        logic [47:0] elapsed_cycles;
        logic [63:0] grand_total_cycles;
    } result_t;

    // Classified item passed from front to back
    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  status;
        logic [15:0] func_id;
        logic [63:0] elapsed;
        logic [4:0]  entry_index;
    } qent_t;

    typedef enum logic {
        F_IDLE,
        F_POP
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_LOOK,
        B_UPD
    } back_state_t;

    function automatic logic [63:0] sat_add64(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? '1 : s[63:0];
    endfunction

endpackage

// File: rtl/core/cpsu_queue.sv
`timescale 1ns / 1ps

module cpsu_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cpsu_pkg::qent_t push_data,
    input  logic            pop,
    output cpsu_pkg::qent_t pop_data,
    output logic            full,
    output logic            empty
);
    localparam int PTR_W = $clog2(cpsu_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(cpsu_pkg::QUEUE_DEPTH + 1);

    cpsu_pkg::qent_t  entries_reg [cpsu_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(cpsu_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entries_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(cpsu_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(cpsu_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/core/cpsu_front.sv
`timescale 1ns / 1ps

module cpsu_front
#(
    parameter int STACK_DEPTH = 16,
    parameter int TIME_BITS   = 48
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  cpsu_pkg::cmd_t  cmd,
    output logic            busy,
    input  logic            q_full,
    output logic            q_push,
    output cpsu_pkg::qent_t q_data
);
    localparam int LVL_W = $clog2(STACK_DEPTH + 1);
    localparam int STK_W = $clog2(STACK_DEPTH);

    cpsu_pkg::front_state_t state_reg, state_next;
    logic [LVL_W-1:0]       level_reg, level_next;
    logic [TIME_BITS-1:0]   ts_reg;
    logic [4:0]             idx_reg;

    logic [15:0]          stk_ids   [STACK_DEPTH];
    logic [TIME_BITS-1:0] stk_starts[STACK_DEPTH];
    logic [15:0]          rd_id_reg;
    logic [TIME_BITS-1:0] rd_start_reg;

    logic                 accept;
    logic                 stk_full;
    logic                 stk_empty;
    logic                 stk_we;
    logic                 stk_re;
    logic [STK_W-1:0]     top_idx;
    logic [TIME_BITS-1:0] ts_in;
    logic [TIME_BITS-1:0] el;

    assign busy      = (state_reg != cpsu_pkg::F_IDLE) || q_full;
    assign accept    = start && !busy;
    assign stk_full  = (level_reg == LVL_W'(STACK_DEPTH));
    assign stk_empty = (level_reg == '0);
    assign top_idx   = STK_W'(level_reg - 1'b1);
    assign ts_in     = TIME_BITS'(cmd.timestamp);
    assign el        = ts_reg - rd_start_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cpsu_pkg::F_IDLE:
            begin
                if (accept && cmd.mode == cpsu_pkg::MODE_LEAVE && !stk_empty)
                begin
                    state_next = cpsu_pkg::F_POP;
                end
            end
            cpsu_pkg::F_POP: state_next = cpsu_pkg::F_IDLE;
            default:         state_next = cpsu_pkg::F_IDLE;
        endcase
    end

    // classification and stack control
    always_comb
    begin
        level_next = level_reg;
        q_push     = 1'b0;
        q_data     = '0;
        stk_we     = 1'b0;
        stk_re     = 1'b0;
        case (state_reg)
            cpsu_pkg::F_IDLE:
            begin
                q_data.mode        = cmd.mode;
                q_data.entry_index = cmd.entry_index;
                if (accept)
                begin
                    case (cmd.mode)
                        cpsu_pkg::MODE_ENTER:
                        begin
                            q_push = 1'b1;
                            if (stk_full)
                            begin
                                q_data.status = cpsu_pkg::ST_STACK_FULL;
                            end
                            else
                            begin
                                stk_we     = 1'b1;
                                level_next = level_reg + 1'b1;
                            end
                        end
                        cpsu_pkg::MODE_LEAVE:
                        begin
                            if (stk_empty)
                            begin
                                q_push        = 1'b1;
                                q_data.status = cpsu_pkg::ST_STACK_EMPT;
                            end
                            else
                            begin
                                stk_re     = 1'b1;
                                level_next = level_reg - 1'b1;
                            end
                        end
                        cpsu_pkg::MODE_FRAME:
                        begin
                            q_push     = 1'b1;
                            level_next = '0;
                        end
                        default:
                        begin
                            q_push = 1'b1;
                        end
                    endcase
                end
            end
            cpsu_pkg::F_POP:
            begin
                q_push              = 1'b1;
                q_data.mode         = cpsu_pkg::MODE_LEAVE;
                q_data.status       = cpsu_pkg::ST_OK;
                q_data.func_id      = rd_id_reg;
                q_data.elapsed      = 64'(el);
                q_data.entry_index  = idx_reg;
            end
            default:
            begin
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpsu_pkg::F_IDLE;
            level_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            level_reg <= level_next;
        end
    end

    // timestamp and entry index held from every accepted item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ts_reg  <= ts_in;
            idx_reg <= cmd.entry_index;
        end
    end

    // call stack memory
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_ids[STK_W'(level_reg)]    <= cmd.func_id;
            stk_starts[STK_W'(level_reg)] <= ts_in;
        end
        if (stk_re)
        begin
            rd_id_reg    <= stk_ids[top_idx];
            rd_start_reg <= stk_starts[top_idx];
        end
    end

endmodule

// File: rtl/core/cpsu_back.sv
`timescale 1ns / 1ps

module cpsu_back
#(
    parameter int TABLE_SLOTS = 32,
    parameter int TIME_BITS   = 48
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  cpsu_pkg::qent_t  q_data,
    output logic             q_pop,
    output logic             done,
    output cpsu_pkg::result_t result
);
    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    typedef struct packed {
        logic [31:0]          calls;
        logic [63:0]          total;
        logic [TIME_BITS-1:0] min;
        logic [TIME_BITS-1:0] max;
    } stats_t;

    cpsu_pkg::back_state_t state_reg, state_next;
    cpsu_pkg::qent_t       op_reg;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic                  alloc_reg, alloc_next;
    logic [63:0]           grand_reg, grand_next;
    logic [TABLE_SLOTS-1:0] valid_reg, valid_next;
    logic [TABLE_SLOTS-1:0] live_reg, live_next;
    logic [15:0]           ids_reg [TABLE_SLOTS];
    stats_t                mem [TABLE_SLOTS];
    stats_t                rd_reg;
    logic                  done_reg, done_next;
    cpsu_pkg::result_t     res_reg, res_next;

    logic                  id_we;
    logic                  mem_we;
    logic                  mem_re;
    logic [SLOT_W-1:0]     mem_ra;
    stats_t                mem_wd;
    stats_t                upd;
    logic                  hit_found;
    logic                  free_found;
    logic [SLOT_W-1:0]     hit_idx;
    logic [SLOT_W-1:0]     free_idx;
    logic [SLOT_W-1:0]     idx_slot;
    logic                  idx_ok;
    logic                  look_upd;
    logic [TIME_BITS-1:0]  el;
    logic [63:0]           grand_sum;
    logic [31:0]           calls_cur;

    assign q_pop     = (state_reg == cpsu_pkg::B_IDLE) && !q_empty;
    assign done      = done_reg;
    assign result    = res_reg;
    assign el        = op_reg.elapsed[TIME_BITS-1:0];
    assign grand_sum = cpsu_pkg::sat_add64(grand_reg, 64'(el));
    assign idx_slot  = SLOT_W'(op_reg.entry_index);
    assign idx_ok    = (32'(op_reg.entry_index) < 32'(TABLE_SLOTS)) && valid_reg[idx_slot];
    assign calls_cur = live_reg[slot_reg] ? rd_reg.calls : 32'd0;

    // tag match and first free slot
    always_comb
    begin
        hit_found  = 1'b0;
        free_found = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        for (int k = 0; k < TABLE_SLOTS; k++)
        begin
            if (valid_reg[k])
            begin
                if (!hit_found && ids_reg[k] == op_reg.func_id)
                begin
                    hit_found = 1'b1;
                    hit_idx   = SLOT_W'(k);
                end
            end
            else if (!free_found)
            begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(k);
            end
        end
    end

    // does the item need the slot read-modify-write step
    always_comb
    begin
        case (op_reg.mode)
            cpsu_pkg::MODE_LEAVE:
                look_upd = (op_reg.status == cpsu_pkg::ST_OK) && (hit_found || free_found);
            cpsu_pkg::MODE_READ:
                look_upd = idx_ok;
            default:
                look_upd = 1'b0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cpsu_pkg::B_IDLE: if (!q_empty) state_next = cpsu_pkg::B_LOOK;
            cpsu_pkg::B_LOOK: state_next = look_upd ? cpsu_pkg::B_UPD : cpsu_pkg::B_IDLE;
            cpsu_pkg::B_UPD:  state_next = cpsu_pkg::B_IDLE;
            default:          state_next = cpsu_pkg::B_IDLE;
        endcase
    end

    // slot update value
    always_comb
    begin
        upd = rd_reg;
        if (alloc_reg)
        begin
            upd.calls = 32'd1;
            upd.total = 64'(el);
            upd.min   = el;
            upd.max   = el;
        end
        else
        begin
            upd.calls = (calls_cur == '1) ? calls_cur : calls_cur + 1'b1;
            upd.total = cpsu_pkg::sat_add64(rd_reg.total, 64'(el));
            upd.min   = (el < rd_reg.min) ? el : rd_reg.min;
            upd.max   = (el > rd_reg.max) ? el : rd_reg.max;
        end
    end

    // outputs and datapath
    always_comb
    begin
        grand_next = grand_reg;
        valid_next = valid_reg;
        live_next  = live_reg;
        slot_next  = slot_reg;
        alloc_next = alloc_reg;
        id_we      = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_ra     = hit_idx;
        mem_wd     = upd;
        done_next  = 1'b0;
        res_next   = '0;
        case (state_reg)
            cpsu_pkg::B_LOOK:
            begin
                res_next.status             = op_reg.status;
                res_next.grand_total_cycles = grand_reg;
                case (op_reg.mode)
                    cpsu_pkg::MODE_LEAVE:
                    begin
                        if (op_reg.status == cpsu_pkg::ST_OK)
                        begin
                            if (hit_found)
                            begin
                                slot_next  = hit_idx;
                                alloc_next = 1'b0;
                                mem_re     = 1'b1;
                            end
                            else if (free_found)
                            begin
                                slot_next  = free_idx;
                                alloc_next = 1'b1;
                            end
                            else
                            begin
                                grand_next                  = grand_sum;
                                done_next                   = 1'b1;
                                res_next.status             = cpsu_pkg::ST_TABLE_FULL;
                                res_next.elapsed_cycles     = 48'(el);
                                res_next.grand_total_cycles = grand_sum;
                            end
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    cpsu_pkg::MODE_READ:
                    begin
                        if (idx_ok)
                        begin
                            slot_next = idx_slot;
                            mem_re    = 1'b1;
                            mem_ra    = idx_slot;
                        end
                        else
                        begin
                            done_next = 1'b1;
                        end
                    end
                    cpsu_pkg::MODE_FRAME:
                    begin
                        grand_next                  = '0;
                        live_next                   = '0;
                        done_next                   = 1'b1;
                        res_next.grand_total_cycles = '0;
                    end
                    default:
                    begin
                        done_next = 1'b1;
                    end
                endcase
            end
            cpsu_pkg::B_UPD:
            begin
                done_next            = 1'b1;
                res_next.entry_valid = 1'b1;
                if (op_reg.mode == cpsu_pkg::MODE_LEAVE)
                begin
                    grand_next                  = grand_sum;
                    valid_next[slot_reg]        = 1'b1;
                    live_next[slot_reg]         = 1'b1;
                    id_we                       = alloc_reg;
                    mem_we                      = 1'b1;
                    res_next.entry_func_id      = op_reg.func_id;
                    res_next.call_count         = upd.calls;
                    res_next.total_cycles       = upd.total;
                    res_next.min_cycles         = 48'(upd.min);
                    res_next.max_cycles         = 48'(upd.max);
                    res_next.elapsed_cycles     = 48'(el);
                    res_next.grand_total_cycles = grand_sum;
                end
                else
                begin
                    res_next.entry_func_id      = ids_reg[slot_reg];
                    res_next.call_count         = calls_cur;
                    res_next.total_cycles       = rd_reg.total;
                    res_next.min_cycles         = 48'(rd_reg.min);
                    res_next.max_cycles         = 48'(rd_reg.max);
                    res_next.grand_total_cycles = grand_reg;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cpsu_pkg::B_IDLE;
            grand_reg <= '0;
            valid_reg <= '0;
            live_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            grand_reg <= grand_next;
            valid_reg <= valid_next;
            live_reg  <= live_next;
            done_reg  <= done_next;
        end
    end

    // payload registers and tag store
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg <= q_data;
        end
        slot_reg  <= slot_next;
        alloc_reg <= alloc_next;
        res_reg   <= res_next;
        if (id_we)
        begin
            ids_reg[slot_reg] <= op_reg.func_id;
        end
    end

    // statistics memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot_reg] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_ra];
        end
    end

    // a popped item is always looked up next
    a_pop_look: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == cpsu_pkg::B_LOOK)
        else $error("popped item not looked up");

    // a frame start clears the grand total
    a_frame_clr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cpsu_pkg::B_LOOK && op_reg.mode == cpsu_pkg::MODE_FRAME)
        |=> grand_reg == '0)
        else $error("grand total not cleared by frame start");

    // slots are never released
    a_valid_keep: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (valid_reg & $past(valid_reg)) == $past(valid_reg))
        else $error("valid slot lost");

    // a live call count only sits in a valid slot
    a_live_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (live_reg & ~valid_reg) == '0)
        else $error("live count in invalid slot");

    // one result per processed item, only from the sequencer
    a_done_src: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != cpsu_pkg::B_IDLE)
        else $error("result without work");

endmodule

// File: rtl/core/call_profile_stats_unit.sv
`timescale 1ns / 1ps
// With the back end idle, done rises after the back-end look-up for enter, frame start,
// read misses and errors; a read of a valid slot or a leave that updates a slot also takes
// the read-modify-write state, and a leave that pops the stack first takes the F_POP state.
// Throughput is set by the back-end slot sequencer, which pops a new item only when idle
// (pop state, look-up state, then a read-modify-write state when a slot is touched).
// Reset clears the stack level, grand total and slot valid bits at once; no clearing pass.
// Results are a one-cycle done strobe: the receiver cannot stall.

module call_profile_stats_unit
#(
    parameter int STACK_DEPTH = 16,
    parameter int TABLE_SLOTS = 32,
    parameter int TIME_BITS   = 48
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  cpsu_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output cpsu_pkg::result_t result
);
    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    cpsu_pkg::qent_t q_in;
    cpsu_pkg::qent_t q_out;

    // stack and classification
    cpsu_front #(
        .STACK_DEPTH (STACK_DEPTH),
        .TIME_BITS   (TIME_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .q_full (q_full),
        .q_push (q_push),
        .q_data (q_in)
    );

    // decoupling queue
    cpsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    // statistics table
    cpsu_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_out),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int DEPTH = 16;
    localparam int SLOTS = 32;
    localparam int N_RANDOM = 1300;

    logic              clk;
    logic              rst_n;
    logic              start;
    cpsu_pkg::cmd_t    cmd;
    logic              busy;
    logic              done;
    cpsu_pkg::result_t result;

    call_profile_stats_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    // Profiler state as the predictor sees it
    logic [15:0] call_ids   [DEPTH];
    logic [47:0] call_starts[DEPTH];
    int          call_depth;
    logic        slot_used  [SLOTS];
    logic [15:0] slot_fid   [SLOTS];
    logic [31:0] slot_calls [SLOTS];
    logic [63:0] slot_sum   [SLOTS];
    logic [47:0] slot_lo    [SLOTS];
    logic [47:0] slot_hi    [SLOTS];
    logic [63:0] frame_total;

    cpsu_pkg::cmd_t    pending_cmds[$];
    cpsu_pkg::result_t expected_results[$];
    int                mismatches;
    bit                stimulus_done;

    // Shadow stack level, kept by the stimulus generator so that
    // well-formed enter/leave sequences can be built
    int      gen_depth;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [63:0] add_saturating(logic [63:0] a, logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

    function automatic void copy_slot(ref cpsu_pkg::result_t r, input int k);
        r.entry_valid   = 1'b1;
        r.entry_func_id = slot_fid[k];
        r.call_count    = slot_calls[k];
        r.total_cycles  = slot_sum[k];
        r.min_cycles    = slot_lo[k];
        r.max_cycles    = slot_hi[k];
    endfunction

    // Work out the result of one accepted item and advance the profiler state
    function automatic cpsu_pkg::result_t profile_step(cpsu_pkg::cmd_t c);
        cpsu_pkg::result_t r;
        logic [15:0]       fid;
        logic [47:0]       el;
        int                hit;
        int                free_slot;
        r = '0;
        case (c.mode)
            cpsu_pkg::MODE_ENTER:
            begin
                if (call_depth >= DEPTH)
                    r.status = cpsu_pkg::ST_STACK_FULL;
                else
                begin
                    call_ids[call_depth]    = c.func_id;
                    call_starts[call_depth] = c.timestamp;
                    call_depth++;
                end
            end
            cpsu_pkg::MODE_LEAVE:
            begin
                if (call_depth == 0)
                    r.status = cpsu_pkg::ST_STACK_EMPT;
                else
                begin
                    call_depth--;
                    fid = call_ids[call_depth];
                    el  = c.timestamp - call_starts[call_depth];
                    frame_total = add_saturating(frame_total, {16'd0, el});
                    r.elapsed_cycles = el;
                    hit = -1;
                    free_slot = -1;
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        if (slot_used[k])
                        begin
                            if (hit < 0 && slot_fid[k] == fid)
                                hit = k;
                        end
                        else if (free_slot < 0)
                            free_slot = k;
                    end
                    if (hit >= 0)
                    begin
                        if (slot_calls[hit] != 32'hFFFF_FFFF)
                            slot_calls[hit]++;
                        slot_sum[hit] = add_saturating(slot_sum[hit], {16'd0, el});
                        if (el < slot_lo[hit])
                            slot_lo[hit] = el;
                        if (el > slot_hi[hit])
                            slot_hi[hit] = el;
                        copy_slot(r, hit);
                    end
                    else if (free_slot >= 0)
                    begin
                        slot_used[free_slot]  = 1'b1;
                        slot_fid[free_slot]   = fid;
                        slot_calls[free_slot] = 32'd1;
                        slot_sum[free_slot]   = {16'd0, el};
                        slot_lo[free_slot]    = el;
                        slot_hi[free_slot]    = el;
                        copy_slot(r, free_slot);
                    end
                    else
                        r.status = cpsu_pkg::ST_TABLE_FULL;
                end
            end
            cpsu_pkg::MODE_FRAME:
            begin
                call_depth  = 0;
                frame_total = '0;
                for (int k = 0; k < SLOTS; k++)
                    slot_calls[k] = '0;
            end
            default:
            begin
                if (slot_used[c.entry_index])
                    copy_slot(r, c.entry_index);
            end
        endcase
        r.grand_total_cycles = frame_total;
        return r;
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom_range(16'hFFFF, 0)), $urandom()};
    endfunction

    // Queue one item, tracking the stack level for sequence building
    function automatic void add_cmd(logic [1:0] m, logic [47:0] ts, logic [15:0] fid,
                                    logic [4:0] idx);
        cpsu_pkg::cmd_t c;
        c.mode        = m;
        c.timestamp   = ts;
        c.func_id     = fid;
        c.entry_index = idx;
        pending_cmds.insert(pending_cmds.size(), c);
        case (m)
            cpsu_pkg::MODE_ENTER: if (gen_depth < DEPTH) gen_depth++;
            cpsu_pkg::MODE_LEAVE: if (gen_depth > 0) gen_depth--;
            cpsu_pkg::MODE_FRAME: gen_depth = 0;
            default: ;
        endcase
    endfunction

    // Stimulus
    initial
    begin
        logic [47:0] now;
        logic [15:0] fid_pool[8];
        int          sel;
        int          n;
        call_depth = 0;
        frame_total = '0;
        gen_depth = 0;
        for (int k = 0; k < SLOTS; k++)
            slot_used[k] = 1'b0;
        stimulus_done = 1'b0;

        // Directed: empty leave, reads of unwritten slots, extremes, wrap, overflow
        add_cmd(cpsu_pkg::MODE_LEAVE, 48'd5, 16'hFFFF, 5'd0);
        add_cmd(cpsu_pkg::MODE_READ, 48'd0, 16'd0, 5'd0);
        add_cmd(cpsu_pkg::MODE_READ, '1, '1, 5'd31);
        add_cmd(cpsu_pkg::MODE_ENTER, '1, 16'hFFFF, 5'd31);
        add_cmd(cpsu_pkg::MODE_LEAVE, 48'd9, 16'd0, 5'd0);       // elapsed wraps round
        add_cmd(cpsu_pkg::MODE_ENTER, 48'd0, 16'd0, 5'd0);
        add_cmd(cpsu_pkg::MODE_LEAVE, '1, '1, '1);               // largest elapsed
        add_cmd(cpsu_pkg::MODE_ENTER, 48'd100, 16'hFFFF, 5'd0);
        add_cmd(cpsu_pkg::MODE_LEAVE, 48'd100, 16'd0, 5'd0);     // zero elapsed, new minimum
        add_cmd(cpsu_pkg::MODE_READ, 48'd0, 16'd0, 5'd0);
        add_cmd(cpsu_pkg::MODE_READ, 48'd0, 16'd0, 5'd1);
        for (int i = 0; i < 17; i++)                             // last one overflows
            add_cmd(cpsu_pkg::MODE_ENTER, 48'(i * 10), 16'(i + 1), 5'(i));
        add_cmd(cpsu_pkg::MODE_FRAME, '1, '1, '1);
        add_cmd(cpsu_pkg::MODE_READ, 48'd0, 16'd0, 5'd0);        // count cleared, stats kept

        // Random: mostly well-formed nested calls over a small id pool
        now = rand48();
        n = 0;
        while (n < N_RANDOM)
        begin
            if ($urandom_range(59, 0) == 0)
            begin
                // occasionally a fresh pool so that the table fills up
                for (int j = 0; j < 8; j++)
                    fid_pool[j] = 16'($urandom());
            end
            else if (n == 0)
            begin
                for (int j = 0; j < 8; j++)
                    fid_pool[j] = 16'($urandom());
            end
            sel = $urandom_range(99, 0);
            now = now + 48'($urandom_range(5000, 0));
            if ($urandom_range(49, 0) == 0)
                now = rand48();
            if (sel < 40 && gen_depth < DEPTH)
                add_cmd(cpsu_pkg::MODE_ENTER, now, fid_pool[$urandom_range(7, 0)],
                        5'($urandom()));
            else if (sel < 80 && gen_depth > 0)
                add_cmd(cpsu_pkg::MODE_LEAVE, now, 16'($urandom()), 5'($urandom()));
            else if (sel < 83)
                add_cmd(cpsu_pkg::MODE_FRAME, rand48(), 16'($urandom()), 5'($urandom()));
            else if (sel < 95)
                add_cmd(cpsu_pkg::MODE_READ, rand48(), 16'($urandom()), 5'($urandom()));
            else
                add_cmd(2'($urandom()), rand48(), 16'($urandom()), 5'($urandom()));
            n++;
        end
        // Drive the stack past full and back below empty once
        for (int i = 0; i < DEPTH + 2; i++)
            add_cmd(cpsu_pkg::MODE_ENTER, rand48(), 16'($urandom()), 5'($urandom()));
        for (int i = 0; i < DEPTH + 2; i++)
            add_cmd(cpsu_pkg::MODE_LEAVE, rand48(), 16'($urandom()), 5'($urandom()));
        for (int i = 0; i < SLOTS; i++)
            add_cmd(cpsu_pkg::MODE_READ, '0, '0, 5'(i));
        stimulus_done = 1'b1;
    end

    // Reset
    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: bursts of items with random gaps between them
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start      <= 1'b0;
            cmd        <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_results.insert(expected_results.size(), profile_step(cmd));
                void'(pending_cmds.pop_front());
            end
            if (start && busy)
                ;  // hold the item until accepted
            else if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end
            else if (pending_cmds.size() > 0)
            begin
                start <= 1'b1;
                cmd   <= pending_cmds[0];
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(12, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 0);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: compare each strobed result against the oldest expectation
    always @(posedge clk)
    begin
        cpsu_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", result);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h got %h", want, result);
                end
            end
        end
    end

    // End of run
    initial
    begin
        mismatches = 0;
        wait (rst_n === 1'b1);
        wait (stimulus_done && pending_cmds.size() == 0 && !start);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("call_profile_stats_unit regression: pass");
        else
            $display("call_profile_stats_unit regression: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("call_profile_stats_unit regression: fail");
        $finish;
    end

endmodule
